// ===== rtl/core/emt_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder tracker package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package emt_pkg;

    localparam int CountW   = 13;
    localparam int SpeedW   = 16;
    localparam int CurrentW = 16;
    localparam int TempW    = 8;
    localparam int TotalW   = 32;
    localparam int ErrorW   = 15;
    localparam int DirW     = 2;

    localparam int InDataW  = 72;
    localparam int OutDataW = 104;

    localparam logic [CountW:0] EncSpan = 14'd8192;

    typedef enum logic
    {
        REQ_FEEDBACK = 1'b0,
        REQ_QUERY    = 1'b1
    } req_kind_t;

    typedef enum logic [DirW-1:0]
    {
        DIR_SHORTEST = 2'd0,
        DIR_CW       = 2'd1,
        DIR_CCW      = 2'd2
    } turn_dir_t;

    typedef struct packed
    {
        req_kind_t             kind;
        logic [CountW-1:0]     encoder_count;
        logic [SpeedW-1:0]     speed_rpm;
        logic [CurrentW-1:0]   phase_current;
        logic [TempW-1:0]      temperature;
        logic [CountW-1:0]     target_count;
        turn_dir_t             turn_direction;
    } cmd_t;

    typedef struct packed
    {
        logic                  seeded;
        logic [ErrorW-1:0]     angle_error;
        logic [TotalW-1:0]     position_total;
        logic [TempW-1:0]      latched_temperature;
        logic [CurrentW-1:0]   latched_current;
        logic [SpeedW-1:0]     latched_speed;
        logic [CountW-1:0]     current_count;
    } result_t;

    typedef struct packed
    {
        logic                  push;
        logic                  full;
    } queue_wr_t;

    typedef struct packed
    {
        logic                  seeded;
        logic                  busy;
    } back_status_t;

endpackage

// ===== rtl/core/motor_encoder_unwrap_tracker.sv =====
// ----------------------------------------------------------------------------
// Motor encoder multiturn tracker
// An accepted word is stored in the queue, its result in the output register.
// Throughput: one word per cycle while m_tready is high, set by the back end's
// state update and output register; the queue absorbs output stalls.
// Reset: asynchronous and active low; all tracker state and the queue clear.
// ----------------------------------------------------------------------------
module motor_encoder_unwrap_tracker
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // encoder_count, speed_rpm, phase_current, temperature, target_count,
    // turn_direction, then zero fill.
    input  logic [emt_pkg::InDataW-1:0]   s_tdata,
    // req_type.
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // current_count, latched_speed, latched_current, latched_temperature,
    // position_total, angle_error, seeded, then zero fill.
    output logic [emt_pkg::OutDataW-1:0]  m_tdata
);
    import emt_pkg::*;

    queue_wr_t    q_wr;
    cmd_t         wr_cmd;
    cmd_t         rd_cmd;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    result_t      result;
    back_status_t status;

    emt_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_cmd    (wr_cmd)
    );

    emt_queue
    #(
        .Depth (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_cmd   (wr_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (rd_cmd)
    );

    emt_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (rd_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result),
        .status   (status)
    );

    assign m_tdata = {(OutDataW - $bits(result_t))'(0), result};

`ifndef SYNTHESIS
    a_seeded_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        status.seeded |=> status.seeded)
        else $error("Seeded flag cleared without a reset.");

    a_error_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(result.angle_error) >= -15'sd8192)
                  && ($signed(result.angle_error) <= 15'sd8192))
        else $error("Angle error outside one revolution.");

    a_unseeded_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !result.seeded) |-> (m_tdata[84:0] == 85'd0))
        else $error("Latched values changed before the first feedback word.");

    a_pop_has_data : assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !status.busy) |=> m_tvalid)
        else $error("Queue was read without a result appearing.");
`endif

endmodule

// ===== rtl/core/emt_front.sv =====
// ----------------------------------------------------------------------------
// Encoder tracker front end
// Unpacks an incoming word, sorts it into a feedback update or an error
// query and hands it to the queue.
// ----------------------------------------------------------------------------
module emt_front
(
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [emt_pkg::InDataW-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  logic                         q_full,
    output emt_pkg::queue_wr_t           q_wr,
    output emt_pkg::cmd_t                q_cmd
);
    import emt_pkg::*;

    req_kind_t kind;

    assign kind     = req_kind_t'(s_tuser);
    assign s_tready = !q_full;

    assign q_wr.push = s_tvalid && !q_full;
    assign q_wr.full = q_full;

    always_comb
    begin
        q_cmd = '0;
        q_cmd.kind = kind;
        case (kind)
            REQ_FEEDBACK:
            begin
                q_cmd.encoder_count = s_tdata[12:0];
                q_cmd.speed_rpm     = s_tdata[28:13];
                q_cmd.phase_current = s_tdata[44:29];
                q_cmd.temperature   = s_tdata[52:45];
            end
            REQ_QUERY:
            begin
                q_cmd.target_count   = s_tdata[65:53];
                q_cmd.turn_direction = turn_dir_t'(s_tdata[67:66]);
            end
            default:
            begin
                q_cmd.kind = REQ_FEEDBACK;
            end
        endcase
    end

endmodule

// ===== rtl/core/emt_queue.sv =====
// ----------------------------------------------------------------------------
// Encoder tracker queue
// A short first-in first-out store between the front and the back end.
// ----------------------------------------------------------------------------
module emt_queue
#(
    parameter int Depth = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  emt_pkg::queue_wr_t  wr,
    input  emt_pkg::cmd_t       wr_cmd,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output emt_pkg::cmd_t       rd_cmd
);
    import emt_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    cmd_t            store [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_pop;

    assign full     = (count_reg == FullCnt);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = store[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !wr.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            store[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/emt_back.sv =====
// ----------------------------------------------------------------------------
// Encoder tracker back end
// Applies feedback updates to the multiturn state, answers error queries and
// holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module emt_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  emt_pkg::cmd_t           q_cmd,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output emt_pkg::result_t        m_result,
    output emt_pkg::back_status_t   status
);
    import emt_pkg::*;

    logic [CountW-1:0]   last_count_reg;
    logic [CountW-1:0]   last_count_next;
    logic [CountW-1:0]   prior_count_reg;
    logic [CountW-1:0]   prior_count_next;
    logic                seeded_reg;
    logic                seeded_next;
    logic [TotalW-1:0]   total_reg;
    logic [TotalW-1:0]   total_next;
    logic [SpeedW-1:0]   speed_reg;
    logic [SpeedW-1:0]   speed_next;
    logic [CurrentW-1:0] current_reg;
    logic [CurrentW-1:0] current_next;
    logic [TempW-1:0]    temp_reg;
    logic [TempW-1:0]    temp_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             out_data_reg;
    result_t             out_data_next;

    logic [CountW:0]     delta;
    logic [CountW:0]     step;
    logic                below;
    logic [CountW-1:0]   diff;
    logic [CountW:0]     rest;
    logic [ErrorW-1:0]   err_diff;
    logic [ErrorW-1:0]   err_rest;
    logic [ErrorW-1:0]   err;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_result = out_data_reg;

    assign status.seeded = seeded_reg;
    assign status.busy   = out_valid_reg;

    // The wrapped candidate differs from the raw delta by the span, which in
    // fourteen bits is the same correction in either direction.
    assign delta = {1'b0, q_cmd.encoder_count} - {1'b0, prior_count_reg};
    always_comb
    begin
        if (($signed(delta) > 14'sd4096) || ($signed(delta) < -14'sd4096))
        begin
            step = delta + EncSpan;
        end
        else
        begin
            step = delta;
        end
    end

    assign below    = (q_cmd.target_count < last_count_reg);
    assign diff     = below ? (last_count_reg - q_cmd.target_count)
                            : (q_cmd.target_count - last_count_reg);
    assign rest     = EncSpan - {1'b0, diff};
    assign err_diff = {2'b00, diff};
    assign err_rest = {1'b0, rest};

    always_comb
    begin
        case (q_cmd.turn_direction)
            DIR_SHORTEST:
            begin
                if (!diff[CountW-1])
                begin
                    err = below ? (-err_diff) : err_diff;
                end
                else
                begin
                    err = below ? err_rest : (-err_rest);
                end
            end
            DIR_CW:
            begin
                err = below ? err_rest : err_diff;
            end
            DIR_CCW:
            begin
                err = below ? (-err_diff) : (-err_rest);
            end
            default:
            begin
                err = '0;
            end
        endcase
    end

    always_comb
    begin
        last_count_next  = last_count_reg;
        prior_count_next = prior_count_reg;
        seeded_next      = seeded_reg;
        total_next       = total_reg;
        speed_next       = speed_reg;
        current_next     = current_reg;
        temp_next        = temp_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
            out_data_next.angle_error = '0;
            case (q_cmd.kind)
                REQ_FEEDBACK:
                begin
                    last_count_next  = q_cmd.encoder_count;
                    prior_count_next = q_cmd.encoder_count;
                    speed_next       = q_cmd.speed_rpm;
                    current_next     = q_cmd.phase_current;
                    temp_next        = q_cmd.temperature;
                    seeded_next      = 1'b1;
                    if (seeded_reg)
                    begin
                        total_next = total_reg + {{(TotalW-CountW-1){step[CountW]}}, step};
                    end
                end
                REQ_QUERY:
                begin
                    out_data_next.angle_error = err;
                end
                default:
                begin
                    out_data_next.angle_error = '0;
                end
            endcase
            out_data_next.current_count       = last_count_next;
            out_data_next.latched_speed       = speed_next;
            out_data_next.latched_current     = current_next;
            out_data_next.latched_temperature = temp_next;
            out_data_next.position_total      = total_next;
            out_data_next.seeded              = seeded_next;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg  <= '0;
            prior_count_reg <= '0;
            seeded_reg      <= 1'b0;
            total_reg       <= '0;
            speed_reg       <= '0;
            current_reg     <= '0;
            temp_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            last_count_reg  <= last_count_next;
            prior_count_reg <= prior_count_next;
            seeded_reg      <= seeded_next;
            total_reg       <= total_next;
            speed_reg       <= speed_next;
            current_reg     <= current_next;
            temp_reg        <= temp_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

// ===== tb/sv/motor_encoder_unwrap_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// Motor encoder multiturn tracker testbench
// Drives feedback and query words into the tracker and checks every output
// word, field by field, against a table or a cycle-free model of the encoder
// unwrap and angular error modes. A short table of boundary cases runs first,
// then random traffic under four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module motor_encoder_unwrap_tracker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import emt_pkg::*;

    localparam int ClkPeriod   = 10;
    localparam int ResetCycles = 8;
    localparam int StallLimit  = 1000;
    localparam int LongHold    = 64;
    localparam int RandomItems = 470;
    localparam int PackedInW   = 2 * CountW + SpeedW + CurrentW + TempW + DirW;

    localparam logic [DirW-1:0] DirUnused = 2'd3;

    typedef struct packed
    {
        req_kind_t             kind;
        logic [CountW-1:0]     count;
        logic [SpeedW-1:0]     speed;
        logic [CurrentW-1:0]   current;
        logic [TempW-1:0]      temp;
        logic [CountW-1:0]     target;
        logic [DirW-1:0]       dir;
    } frame_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OutDataW-1:0]   m_tdata;

    logic [CountW-1:0]     trk_last    = '0;
    logic [CountW-1:0]     trk_prior   = '0;
    logic                  trk_seeded  = 1'b0;
    logic [TotalW-1:0]     trk_total   = '0;
    logic [SpeedW-1:0]     trk_speed   = '0;
    logic [CurrentW-1:0]   trk_current = '0;
    logic [TempW-1:0]      trk_temp    = '0;

    result_t               pending_readings[$];
    frame_t                table_frames[$];
    result_t               table_wants[$];
    bit                    table_known[$];

    int                    mismatches     = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    hold_requests  = 0;
    result_t               got_word;
    result_t               want_word;

    motor_encoder_unwrap_tracker DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    function automatic logic [ErrorW-1:0] error_to_target(logic [CountW-1:0] cur,
                                                          logic [CountW-1:0] tgt,
                                                          logic [DirW-1:0] dir);
        bit below;
        int diff;
        int rest;
        int err;
        below = tgt < cur;
        diff  = below ? int'(cur) - int'(tgt) : int'(tgt) - int'(cur);
        rest  = int'(EncSpan) - diff;
        case (dir)
            DIR_SHORTEST: err = (diff < rest) ? (below ? -diff : diff) : (below ? rest : -rest);
            DIR_CW:       err = below ? rest : diff;
            DIR_CCW:      err = below ? -diff : -rest;
            default:      err = 0;
        endcase
        return err[ErrorW-1:0];
    endfunction

    function automatic result_t track_frame(frame_t f);
        result_t r;
        int      d;
        int      alt;
        r.angle_error = '0;
        if (f.kind == REQ_FEEDBACK)
        begin
            trk_last    = f.count;
            trk_speed   = f.speed;
            trk_current = f.current;
            trk_temp    = f.temp;
            if (!trk_seeded)
            begin
                trk_seeded = 1'b1;
            end
            else
            begin
                d   = int'(f.count) - int'(trk_prior);
                alt = (d > 0) ? d - int'(EncSpan) : d + int'(EncSpan);
                if ((alt < 0 ? -alt : alt) < (d < 0 ? -d : d))
                    d = alt;
                trk_total = trk_total + TotalW'(d);
            end
            trk_prior = f.count;
        end
        else
        begin
            r.angle_error = error_to_target(trk_last, f.target, f.dir);
        end
        r.current_count       = trk_last;
        r.latched_speed       = trk_speed;
        r.latched_current     = trk_current;
        r.latched_temperature = trk_temp;
        r.position_total      = trk_total;
        r.seeded              = trk_seeded;
        return r;
    endfunction

    function automatic frame_t feedback(int cnt, int spd, int cur, int tmp);
        frame_t f;
        f.kind    = REQ_FEEDBACK;
        f.count   = CountW'(cnt);
        f.speed   = SpeedW'(spd);
        f.current = CurrentW'(cur);
        f.temp    = TempW'(tmp);
        f.target  = '1;
        f.dir     = DirUnused;
        return f;
    endfunction

    function automatic frame_t query(int tgt, logic [DirW-1:0] dir);
        frame_t f;
        f.kind    = REQ_QUERY;
        f.count   = '1;
        f.speed   = '1;
        f.current = '1;
        f.temp    = '1;
        f.target  = CountW'(tgt);
        f.dir     = dir;
        return f;
    endfunction

    function automatic result_t reading(int cnt, int spd, int cur, int tmp, int tot,
                                        int err, bit sd);
        result_t r;
        r.current_count       = CountW'(cnt);
        r.latched_speed       = SpeedW'(spd);
        r.latched_current     = CurrentW'(cur);
        r.latched_temperature = TempW'(tmp);
        r.position_total      = TotalW'(tot);
        r.angle_error         = ErrorW'(err);
        r.seeded              = sd;
        return r;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     pick;
        int     offs;
        f.kind    = ($urandom_range(99) < 55) ? REQ_FEEDBACK : REQ_QUERY;
        f.count   = CountW'($urandom);
        f.speed   = SpeedW'($urandom);
        f.current = CurrentW'($urandom);
        f.temp    = TempW'($urandom);
        f.target  = CountW'($urandom);
        f.dir     = ($urandom_range(9) == 0) ? DirUnused : DirW'($urandom_range(2));
        pick      = $urandom_range(9);
        offs      = 4095 + $urandom_range(2);
        if ($urandom_range(1) == 1)
            offs = -offs;
        if (f.kind == REQ_FEEDBACK)
        begin
            case (pick)
                0, 1, 2, 3: f.count = CountW'(int'(trk_prior) + $urandom_range(200) - 100);
                4:          f.count = CountW'(int'(trk_prior) + offs);
                5:          f.count = trk_prior;
                6:          f.count = ($urandom_range(1) == 1) ? '1 : '0;
                default:    ;
            endcase
        end
        else
        begin
            case (pick)
                0, 1:    f.target = trk_last;
                2:       f.target = CountW'(int'(trk_last) + 4096);
                3, 4:    f.target = CountW'(int'(trk_last) + offs);
                5:       f.target = ($urandom_range(1) == 1) ? '1 : '0;
                default: ;
            endcase
        end
        return f;
    endfunction

    task automatic send_frame(frame_t f, bit known, result_t want);
        result_t modelled;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f.kind;
        s_tdata  <= {{(InDataW - PackedInW){1'b0}}, f.dir, f.target, f.temp, f.current,
                     f.speed, f.count};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        modelled = track_frame(f);
        pending_readings.push_back(known ? want : modelled);
    endtask

    task automatic wait_all_readings();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string what, logic [TotalW-1:0] want_v,
                               logic [TotalW-1:0] got_v);
        if (want_v !== got_v)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0h got %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word = m_tdata[$bits(result_t)-1:0];
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: output word with nothing pending, expected none got %0h",
                         $time, m_tdata);
            end
            else
            begin
                want_word = pending_readings.pop_front();
                check_field("current_count", TotalW'(want_word.current_count),
                            TotalW'(got_word.current_count));
                check_field("latched_speed", TotalW'(want_word.latched_speed),
                            TotalW'(got_word.latched_speed));
                check_field("latched_current", TotalW'(want_word.latched_current),
                            TotalW'(got_word.latched_current));
                check_field("latched_temperature", TotalW'(want_word.latched_temperature),
                            TotalW'(got_word.latched_temperature));
                check_field("position_total", want_word.position_total,
                            got_word.position_total);
                check_field("angle_error", TotalW'(want_word.angle_error),
                            TotalW'(got_word.angle_error));
                check_field("seeded", TotalW'(want_word.seeded), TotalW'(got_word.seeded));
            end
        end
    end

    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = LongHold;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        result_t none;
        none     = '0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;

        table_frames.push_back(query(0, DIR_SHORTEST));
        table_wants.push_back(reading(0, 0, 0, 0, 0, 0, 1'b0));
        table_frames.push_back(query(0, DIR_CCW));
        table_wants.push_back(reading(0, 0, 0, 0, 0, -8192, 1'b0));
        table_frames.push_back(query(8191, DIR_CW));
        table_wants.push_back(reading(0, 0, 0, 0, 0, 8191, 1'b0));
        table_frames.push_back(query(100, DirUnused));
        table_wants.push_back(reading(0, 0, 0, 0, 0, 0, 1'b0));
        table_frames.push_back(query(8191, DIR_SHORTEST));
        table_wants.push_back(reading(0, 0, 0, 0, 0, -1, 1'b0));
        table_frames.push_back(feedback(8191, 32767, -32768, 255));
        table_wants.push_back(reading(8191, 32767, -32768, 255, 0, 0, 1'b1));
        table_frames.push_back(feedback(0, -32768, 32767, 0));
        table_wants.push_back(reading(0, -32768, 32767, 0, 1, 0, 1'b1));
        table_frames.push_back(feedback(4096, 1, -1, 7));
        table_wants.push_back(reading(4096, 1, -1, 7, 4097, 0, 1'b1));
        table_frames.push_back(feedback(0, 1, -1, 7));
        table_wants.push_back(reading(0, 1, -1, 7, 1, 0, 1'b1));
        table_frames.push_back(query(4096, DIR_SHORTEST));
        table_wants.push_back(reading(0, 1, -1, 7, 1, -4096, 1'b1));
        for (int i = 0; i < table_wants.size(); i++)
            table_known.push_back(1'b1);

        table_frames.push_back(feedback(4096, 300, -300, 90));
        table_frames.push_back(query(0, DIR_SHORTEST));
        table_frames.push_back(query(0, DIR_CW));
        table_frames.push_back(query(4096, DIR_CCW));
        table_frames.push_back(query(4096, DIR_CW));
        table_frames.push_back(query(4096, DIR_SHORTEST));
        table_frames.push_back(query(8191, DIR_CCW));
        table_frames.push_back(query(8191, DIR_SHORTEST));
        table_frames.push_back(query(0, DIR_CCW));
        table_frames.push_back(feedback(8191, 0, 0, 128));
        table_frames.push_back(feedback(0, -1, 1, 1));
        table_frames.push_back(feedback(8191, 12345, -12345, 254));
        table_frames.push_back(feedback(8191, 0, 0, 0));
        table_frames.push_back(query(0, DirUnused));
        table_frames.push_back(query(8191, DIR_CCW));
        while (table_known.size() < table_frames.size())
        begin
            table_known.push_back(1'b0);
            table_wants.push_back(none);
        end

        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < table_frames.size(); i++)
            send_frame(table_frames[i], table_known[i], table_wants[i]);
        wait_all_readings();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            for (int n = 0; n < RandomItems; n++)
            begin
                if (phase == 0 && n == 200)
                    hold_requests++;
                send_frame(random_frame(), 1'b0, none);
            end
            wait_all_readings();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/emt_pkg.sv
rtl/core/emt_front.sv
rtl/core/emt_queue.sv
rtl/core/emt_back.sv
rtl/core/motor_encoder_unwrap_tracker.sv
tb/sv/motor_encoder_unwrap_tracker_tb.sv
